[sv/sms_pkg.sv]
// Shared types and constants for the substring match stream unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package sms_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;
    localparam int LEN_W      = 4;
    localparam int COUNT_W    = 16;
    localparam int PAT_BYTES  = CFG_DATA_W / BYTE_W;
    localparam int PAT_IDX_W  = $clog2(PAT_BYTES);

    // Register select is paddr[3]: registers sit 8 bytes apart
    typedef enum logic
    {
        REG_PATTERN = 1'b0,
        REG_LENGTH  = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/sms_cfg.sv]
// APB register file: search pattern and pattern length.
// Depends on sms_pkg.
`default_nettype none

module sms_cfg
    import sms_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [CFG_DATA_W-1:0] pattern,
    output logic      [LEN_W-1:0]      pattern_length
);

    logic [CFG_DATA_W-1:0] pattern_reg;
    logic [LEN_W-1:0]      length_reg;
    cfg_reg_t              sel;
    logic                  wr_en;

    assign sel    = cfg_reg_t'(paddr[3]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= LEN_W'(1);
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_PATTERN: pattern_reg <= pwdata;
                REG_LENGTH:  length_reg  <= pwdata[LEN_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_PATTERN: prdata = pattern_reg;
            REG_LENGTH:  prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, length_reg};
            default:     prdata = '0;
        endcase
    end

    assign pattern        = pattern_reg;
    assign pattern_length = length_reg;

endmodule

`default_nettype wire

[sv/sms_cell.sv]
// One window cell: holds a text byte, passes it on, compares the incoming byte.
// Depends on sms_pkg.
`default_nettype none

module sms_cell
    import sms_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [BYTE_W-1:0] byte_in,
    input  wire logic [BYTE_W-1:0] pat_byte,
    input  wire logic              lane_on,
    output logic      [BYTE_W-1:0] byte_out,
    output logic                   hit
);

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    // compare against the value this cell takes on the shift
    assign hit = !lane_on || (byte_in == pat_byte);

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.shift)
        begin
            byte_next = ctrl.clear ? '0 : byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

[sv/substring_match_stream_unit.sv]
// Streaming substring search against a 1..8 byte pattern.
// Channels: s_* carries one text byte per transaction, s_tlast marks the final
// byte of a text. m_* carries one result per byte that ends an occurrence or
// is marked last; m_tlast is set on the result for the final byte, with the
// total occurrence count. m_tuser holds the found and position overflow flags.
// The APB port sets the pattern (address 0x0) and its length (address 0x8);
// write it only while no text is in flight.
// Results are registered and reach m_* the cycle after their byte is accepted.
// Throughput: one byte per cycle unless m_* stalls; a row of byte cells
// shifts the window and tests each lane in parallel in the accepting cycle.
// A single output register sits between the channels: s_tready stays high
// while the result register is empty or being drained, so a stalled
// receiver holds back at most one result and then stalls the sender.
// Reset clears the window, position, count and overflow flag, sets the
// pattern to zero and its length to 1. The final byte of a text clears the
// same state after its result is formed.
// Parameters: PATTERN_MAX sets the number of cells, POSITION_MAX the
// saturation point of the position counter.
`default_nettype none

module substring_match_stream_unit
    import sms_pkg::*;
#(
    parameter int              PATTERN_MAX  = 8,
    parameter longint unsigned POSITION_MAX = 65535
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // APB configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    // text input
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] text_byte
    input  wire logic                  s_tlast,   // text_last
    // results
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [47:0]           m_tdata,   // [15:0] start_position,
                                                  // [31:16] end_position,
                                                  // [47:32] occurrences
    output logic                       m_tlast,   // text_done
    output logic      [1:0]            m_tuser    // [0] found, [1] position_overflow
);

    localparam int POS_W = $clog2(POSITION_MAX + 1);
    localparam logic [POS_W-1:0] POS_MAX_V = POS_W'(POSITION_MAX);
    localparam logic [LEN_W-1:0] LEN_MAX_V = LEN_W'(PATTERN_MAX);

    logic [CFG_DATA_W-1:0] pattern;
    logic [LEN_W-1:0]      pattern_length;
    logic [LEN_W-1:0]      len_eff;

    logic                  accept;
    cell_ctrl_t            ctrl;
    logic [BYTE_W-1:0]     link [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] hit;

    logic [POS_W-1:0]      pos_reg, pos_next, pos_new;
    logic [COUNT_W-1:0]    total_reg, total_next, total_new;
    logic                  ovf_reg, ovf_next, ovf_new;
    logic                  pos_sat, match, emit;
    logic [COUNT_W-1:0]    end16, start16;

    logic                  m_valid_reg, m_valid_next;
    logic [47:0]           m_data_reg;
    logic                  m_last_reg;
    logic [1:0]            m_user_reg;

    sms_cfg u_cfg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .pattern        (pattern),
        .pattern_length (pattern_length)
    );

    always_comb
    begin
        if (pattern_length == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (pattern_length > LEN_MAX_V)
        begin
            len_eff = LEN_MAX_V;
        end
        else
        begin
            len_eff = pattern_length;
        end
    end

    assign s_tready   = !m_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign ctrl.shift = accept;
    assign ctrl.clear = s_tlast;

    // cell d compares the byte received d transactions ago and matches pattern
    // byte len-1-d
    for (genvar d = 0; d < PATTERN_MAX; d++)
    begin : g_cell
        logic [BYTE_W-1:0]    cell_in;
        logic [LEN_W-1:0]     pat_pos;
        logic [PAT_IDX_W-1:0] pat_idx;
        logic                 lane_on;

        assign pat_pos = len_eff - LEN_W'(1) - LEN_W'(d);
        assign pat_idx = pat_pos[PAT_IDX_W-1:0];
        assign lane_on = LEN_W'(d) < len_eff;

        if (d == 0)
        begin : g_head
            assign cell_in = s_tdata;
        end
        else
        begin : g_body
            assign cell_in = link[d-1];
        end

        sms_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .byte_in  (cell_in),
            .pat_byte (pattern[BYTE_W*pat_idx +: BYTE_W]),
            .lane_on  (lane_on),
            .byte_out (link[d]),
            .hit      (hit[d])
        );
    end

    always_comb
    begin
        pos_sat   = pos_reg >= POS_MAX_V;
        pos_new   = pos_sat ? POS_MAX_V : pos_reg + POS_W'(1);
        ovf_new   = ovf_reg || pos_sat;
        match     = (&hit) && (ovf_new || (pos_new >= POS_W'(len_eff)));
        total_new = (match && (total_reg != '1)) ? total_reg + COUNT_W'(1) : total_reg;
        end16     = COUNT_W'(pos_new);
        start16   = end16 - COUNT_W'(len_eff) + COUNT_W'(1);
        emit      = match || s_tlast;

        pos_next   = pos_reg;
        total_next = total_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            pos_next   = s_tlast ? '0 : pos_new;
            total_next = s_tlast ? '0 : total_new;
            ovf_next   = s_tlast ? 1'b0 : ovf_new;
        end

        m_valid_next = m_valid_reg && !m_tready;
        if (accept && emit)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            total_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            total_reg   <= total_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            m_data_reg <= {total_new,
                           match ? end16 : COUNT_W'(0),
                           match ? start16 : COUNT_W'(0)};
            m_last_reg <= s_tlast;
            m_user_reg <= {ovf_new, match};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> 16'(m_tdata[31:16] - m_tdata[15:0]) < 16'(PATTERN_MAX))
        else $error("occurrence span exceeds pattern size");

    a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[31:0] == 32'd0)
        else $error("result without occurrence is not a final-byte result");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> pos_reg == '0 && total_reg == '0 && !ovf_reg)
        else $error("text state not cleared after final byte");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !s_tlast && !pos_sat |=> pos_reg == $past(pos_reg) + POS_W'(1))
        else $error("position did not advance");

endmodule

`default_nettype wire

[bench/substring_match_stream_unit_tb.sv]
// Self-checking bench for substring_match_stream_unit: APB pattern set-up,
// directed table, then random texts under idling, a long stall and a drain pause.
// Depends on sms_pkg and the unit itself.
module substring_match_stream_unit_tb;
    import sms_pkg::*;

    localparam int          LIMIT_CYCLES = 400000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          SETTINGS_N   = 8;
    localparam int          TEXT_CHUNK   = 130;
    localparam logic [15:0] POS_LIMIT    = 16'hFFFF;

    typedef struct packed
    {
        logic        found;
        logic [15:0] start_pos;
        logic [15:0] end_pos;
        logic [15:0] count;
        logic        done;
        logic        ovf;
    } match_report_t;

    typedef enum logic [1:0]
    {
        ROW_BYTE,
        ROW_PATTERN,
        ROW_LENGTH
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t     kind;
        logic [63:0]   value;
        logic          last;
        logic          has_report;
        match_report_t report;
    } plan_row_t;

    localparam match_report_t NO_REPORT = '0;

    localparam plan_row_t DIRECTED_PLAN [23] = '{
        // reset pattern is one zero byte
        '{ROW_BYTE,    64'h00, 1'b0, 1'b1, '{1'b1, 16'd1, 16'd1, 16'd1, 1'b0, 1'b0}},
        '{ROW_BYTE,    64'hFF, 1'b0, 1'b0, NO_REPORT},
        '{ROW_BYTE,    64'h00, 1'b1, 1'b1, '{1'b1, 16'd3, 16'd3, 16'd2, 1'b1, 1'b0}},
        // length zero acts as one
        '{ROW_PATTERN, 64'hFF, 1'b0, 1'b0, NO_REPORT},
        '{ROW_LENGTH,  64'h0,  1'b0, 1'b0, NO_REPORT},
        '{ROW_BYTE,    64'hFF, 1'b0, 1'b1, '{1'b1, 16'd1, 16'd1, 16'd1, 1'b0, 1'b0}},
        '{ROW_BYTE,    64'h7F, 1'b0, 1'b0, NO_REPORT},
        '{ROW_BYTE,    64'hFF, 1'b1, 1'b1, '{1'b1, 16'd3, 16'd3, 16'd2, 1'b1, 1'b0}},
        // length fifteen acts as eight
        '{ROW_PATTERN, 64'h0807060504030201, 1'b0, 1'b0, NO_REPORT},
        '{ROW_LENGTH,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, NO_REPORT},
        '{ROW_BYTE,    64'h01, 1'b0, 1'b0, NO_REPORT},
        '{ROW_BYTE,    64'h02, 1'b0, 1'b0, NO_REPORT},
        '{ROW_BYTE,    64'h03, 1'b0, 1'b0, NO_REPORT},
        '{ROW_BYTE,    64'h04, 1'b0, 1'b0, NO_REPORT},
        '{ROW_BYTE,    64'h05, 1'b0, 1'b0, NO_REPORT},
        '{ROW_BYTE,    64'h06, 1'b0, 1'b0, NO_REPORT},
        '{ROW_BYTE,    64'h07, 1'b0, 1'b0, NO_REPORT},
        '{ROW_BYTE,    64'h08, 1'b1, 1'b1, '{1'b1, 16'd1, 16'd8, 16'd1, 1'b1, 1'b0}},
        // zero window must not match a text shorter than the pattern
        '{ROW_PATTERN, 64'h0,  1'b0, 1'b0, NO_REPORT},
        '{ROW_LENGTH,  64'h8,  1'b0, 1'b0, NO_REPORT},
        '{ROW_BYTE,    64'h00, 1'b0, 1'b0, NO_REPORT},
        '{ROW_BYTE,    64'h00, 1'b0, 1'b0, NO_REPORT},
        '{ROW_BYTE,    64'h00, 1'b1, 1'b1, '{1'b0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0}}
    };

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;  // [7:0] text_byte
    logic                  s_tlast  = 1'b0;  // text_last
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [47:0]           m_tdata;  // [15:0] start, [31:16] end, [47:32] occurrences
    logic                  m_tlast;  // text_done
    logic [1:0]            m_tuser;  // [0] found, [1] position_overflow

    // predictor state
    logic [63:0]   cfg_pattern;
    logic [3:0]    cfg_length;
    logic [63:0]   text_window;
    logic [15:0]   text_pos;
    logic [15:0]   hit_total;
    logic          pos_saturated;
    match_report_t pending_reports [$];

    int            fails         = 0;
    int            reports_seen  = 0;
    int            bytes_sent    = 0;
    int            cycles        = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_requests = 0;
    int            hold_served   = 0;
    int            hold_left     = 0;
    match_report_t want;

    substring_match_stream_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int unsigned active_length();
        if (cfg_length == 4'd0)
            return 1;
        if (cfg_length > PAT_BYTES)
            return PAT_BYTES;
        return cfg_length;
    endfunction

    function automatic bit scan_byte(input logic [7:0] b, input logic l,
                                     output match_report_t rep);
        int unsigned n;
        int unsigned k;
        logic        hit;
        n = active_length();
        rep = '0;
        text_window = {text_window[55:0], b};
        if (text_pos == POS_LIMIT)
            pos_saturated = 1'b1;
        else
            text_pos = text_pos + 16'd1;
        hit = pos_saturated || (text_pos >= n);
        for (k = 0; k < n; k++)
            if (cfg_pattern[8*k +: 8] != text_window[8*(n-1-k) +: 8])
                hit = 1'b0;
        if (hit)
        begin
            rep.found     = 1'b1;
            rep.end_pos   = text_pos;
            rep.start_pos = 16'(text_pos - n + 1);
            if (hit_total != 16'hFFFF)
                hit_total = hit_total + 16'd1;
        end
        rep.count = hit_total;
        rep.done  = l;
        rep.ovf   = pos_saturated;
        if (l)
        begin
            text_window   = '0;
            text_pos      = '0;
            hit_total     = '0;
            pos_saturated = 1'b0;
        end
        return hit || l;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_reg_t sel, input logic [63:0] v);
        logic ok;
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            ok = pready;
            @(posedge clk);
        end
        while (!ok);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_PATTERN)
            cfg_pattern = v;
        else
            cfg_length = v[3:0];
    endtask

    // typed: expectation given by the caller instead of the predictor
    task automatic push_byte(input logic [7:0] b, input logic l, input bit typed,
                             input bit typed_has, input match_report_t typed_rep);
        logic          took;
        bit            has;
        match_report_t rep;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do
        begin
            @(negedge clk);
            took = s_tready;
            @(posedge clk);
        end
        while (!took);
        has = scan_byte(b, l, rep);
        if (typed)
        begin
            has = typed_has;
            rep = typed_rep;
        end
        if (has)
            pending_reports.push_back(rep);
        bytes_sent++;
    endtask

    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            fails++;
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
        end
    endtask

    // handshake values are settled at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            reports_seen++;
            if (pending_reports.size() == 0)
            begin
                fails++;
                $error("result transaction with nothing expected");
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("found", 16'(want.found), 16'(m_tuser[0]));
                check_field("start_position", want.start_pos, m_tdata[15:0]);
                check_field("end_position", want.end_pos, m_tdata[31:16]);
                check_field("occurrences", want.count, m_tdata[47:32]);
                check_field("text_done", 16'(want.done), 16'(m_tlast));
                check_field("position_overflow", 16'(want.ovf), 16'(m_tuser[1]));
            end
        end
    end

    initial
    begin
        plan_row_t   row;
        logic [63:0] pat;
        logic [7:0]  sym_a;
        logic [7:0]  sym_b;
        logic [7:0]  text_buf [$];
        logic [3:0]  len_code;
        int unsigned n;
        int          s;
        int          k;
        int          r;
        int          random_sent;

        cfg_pattern   = '0;
        cfg_length    = 4'd1;
        text_window   = '0;
        text_pos      = '0;
        hit_total     = '0;
        pos_saturated = 1'b0;
        random_sent   = 0;
        send_idle_pct = 25;
        recv_idle_pct = 68;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_PLAN[i])
        begin
            row = DIRECTED_PLAN[i];
            case (row.kind)
                ROW_PATTERN: cfg_write(REG_PATTERN, row.value);
                ROW_LENGTH:  cfg_write(REG_LENGTH, row.value);
                default:     push_byte(row.value[7:0], row.last, 1'b1,
                                       row.has_report, row.report);
            endcase
        end

        for (s = 0; s < SETTINGS_N; s++)
        begin
            case (s)
                0:       len_code = 4'd1;
                1:       len_code = 4'd8;
                2:       len_code = 4'd0;
                3:       len_code = 4'd15;
                default: len_code = 4'($urandom_range(2, 7));
            endcase
            cfg_write(REG_LENGTH, ({$urandom, $urandom} & ~64'hF) | 64'(len_code));
            n     = active_length();
            sym_a = 8'($urandom);
            sym_b = 8'($urandom);
            for (k = 0; k < PAT_BYTES; k++)
                pat[8*k +: 8] = (k >= n) ? 8'($urandom)
                              : ($urandom_range(1) ? sym_a : sym_b);
            cfg_write(REG_PATTERN, pat);

            // mostly pattern copies and pattern symbols, some arbitrary bytes
            text_buf.delete();
            while (text_buf.size() < TEXT_CHUNK)
            begin
                r = $urandom_range(99);
                if (r < 35)
                    for (k = 0; k < n; k++)
                        text_buf.push_back(pat[8*k +: 8]);
                else if (r < 90)
                    text_buf.push_back($urandom_range(1) ? sym_a : sym_b);
                else
                    text_buf.push_back(8'($urandom));
            end

            foreach (text_buf[i])
            begin
                if (random_sent < 350)
                begin
                    send_idle_pct = 25;
                    recv_idle_pct = 68;
                end
                else if (random_sent < 700)
                begin
                    send_idle_pct = 68;
                    recv_idle_pct = 25;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                if (s == 3 && i == 20)
                    hold_requests++;
                if (s == 5 && i == 60)
                    wait_drained();
                push_byte(text_buf[i], (i == text_buf.size() - 1) || ($urandom_range(15) == 0),
                          1'b0, 1'b0, NO_REPORT);
                random_sent++;
            end
        end

        wait_drained();
        repeat (5) @(posedge clk);
        $display("%0d text bytes over %0d pattern settings, %0d results compared",
                 bytes_sent, SETTINGS_N + 4, reports_seen);
        $display("covered: length limits, short texts, overlaps, long stall, drain pause");
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
sv/sms_pkg.sv
sv/sms_cfg.sv
sv/sms_cell.sv
sv/substring_match_stream_unit.sv
bench/substring_match_stream_unit_tb.sv
